### design/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg: shared types, constants and tables for unix_seconds_to_date
// Constant divisors, their truncated reciprocals and the small calendar tables
// used by the time split, civil date and weekday pipelines.
// ----------------------------------------------------------------------------
package usd_pkg;

  // Pipeline depths of the three sections
  localparam int TsplitDepth = 8;
  localparam int CivilDepth  = 10;
  localparam int WdayDepth   = 5;

  // Seconds per day is 128 * 675
  localparam int unsigned DayShift   = 7;
  localparam int unsigned DayDivOdd  = 675;
  localparam int unsigned RecipHi    = 97;      // floor(2^16 / 675)
  localparam int unsigned RecipLo    = 198841;  // floor(2^27 / 675)
  localparam int unsigned SixtyDiv   = 60;
  localparam int unsigned RecipSod   = 2184;    // floor(2^17 / 60)
  localparam int unsigned RecipMt    = 34;      // floor(2^11 / 60)

  // Julian-day conversion
  localparam int unsigned CentNum    = 102032;
  localparam int unsigned CentDiv    = 146097;
  localparam int unsigned CentRecip  = 459;     // floor(2^26 / 146097)
  localparam int unsigned CentBias   = 15;
  localparam int unsigned GbOffset   = 2442113;
  localparam int unsigned YrSub      = 2442;
  localparam int unsigned YrDiv      = 7305;
  localparam int unsigned YrRecip    = 73493;   // floor(2^29 / 7305)
  localparam int unsigned DaysInYear = 365;
  localparam int unsigned MonthDays  = 30;
  localparam int unsigned LastShifted = 13;     // last month index before Jan/Feb
  localparam int unsigned YrOffLo    = 4716;
  localparam int unsigned YrOffHi    = 4715;

  // Zeller
  localparam int unsigned HundredDiv   = 100;
  localparam int unsigned HundredRecip = 655;   // floor(2^16 / 100)
  localparam int unsigned WeekDiv      = 7;
  localparam int unsigned WeekRecip    = 585;   // floor(2^12 / 7)
  localparam int unsigned WeekBias     = 5;

  // First dy of month index k+1: ceil(30.601 * (k+1))
  localparam logic [8:0] MonthStart [15] = '{
    9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
    9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
  };

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
  } tod_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_t;

  // floor(dy * 1000 / 30601) by threshold count
  function automatic logic [3:0] month_index(logic [8:0] dy);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 0; k < 15; k++) begin
      if (dy >= MonthStart[k]) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

  // floor(mo * 601 / 1000)
  function automatic logic [3:0] month_frac(logic [3:0] mo);
    logic [3:0] f;
    unique case (mo)
      4'd0, 4'd1:   f = 4'd0;
      4'd2, 4'd3:   f = 4'd1;
      4'd4:         f = 4'd2;
      4'd5, 4'd6:   f = 4'd3;
      4'd7, 4'd8:   f = 4'd4;
      4'd9:         f = 4'd5;
      4'd10, 4'd11: f = 4'd6;
      4'd12, 4'd13: f = 4'd7;
      4'd14:        f = 4'd8;
      default:      f = 4'd9;
    endcase
    return f;
  endfunction

  // floor(26 * (m + 1) / 10)
  function automatic logic [5:0] zeller_month_term(logic [3:0] m);
    logic [5:0] t;
    unique case (m)
      4'd0:    t = 6'd2;
      4'd1:    t = 6'd5;
      4'd2:    t = 6'd7;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd41;
    endcase
    return t;
  endfunction

endpackage

### design/usd_pipe_ctl.sv
// ----------------------------------------------------------------------------
// usd_pipe_ctl: valid/ready control for a linear pipeline
// Tracks one valid bit per stage and gives each stage its load enable, so
// bubbles collapse and a stall at the end backs up stage by stage.
// ----------------------------------------------------------------------------
module usd_pipe_ctl #(
  parameter int Depth = usd_pkg::WdayDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Depth-1:0] en_o
);

  logic [Depth-1:0] v_q;
  logic [Depth-1:0] en;

  // A stage loads when it is empty or its content moves on this cycle
  always_comb begin
    en[Depth-1] = ~v_q[Depth-1] | ready_i;
    for (int k = Depth - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Depth; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign en_o    = en;
  assign ready_o = en[0];
  assign valid_o = v_q[Depth-1];

endmodule

### design/usd_tsplit.sv
// ----------------------------------------------------------------------------
// usd_tsplit: seconds count to day count and time of day
// Divides by 86400 as a shift by 7 and a two-chunk divide by 675, then
// splits the second of day by 60 twice. Each divide is a reciprocal
// estimate stage followed by a one-step correction stage.
// ----------------------------------------------------------------------------
module usd_tsplit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [39:0]         unix_seconds_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [23:0]         days_o,
  output usd_pkg::tod_t       tod_o
);

  localparam int Depth = usd_pkg::TsplitDepth;

  logic [Depth-1:0] en;

  usd_pipe_ctl #(.Depth(Depth)) u_ctl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .valid_o (valid_o),
    .ready_i (ready_i),
    .en_o    (en)
  );

  // Stage 1: estimate upper chunk / 675
  logic [32:0] s1_x;
  logic [22:0] s1_prod;
  logic [6:0]  s1_qe_q;
  logic [15:0] s1_a_q;
  logic [16:0] s1_b_q;
  logic [6:0]  s1_lo_q;

  assign s1_x    = unix_seconds_i[39:usd_pkg::DayShift];
  assign s1_prod = 23'(s1_x[32:17]) * 23'(usd_pkg::RecipHi);

  // Stage 2: correct upper chunk
  logic [16:0] s2_rem;
  logic [6:0]  s2_qa_d;
  logic [9:0]  s2_ra_d;
  logic [6:0]  s2_qa_q;
  logic [9:0]  s2_ra_q;
  logic [16:0] s2_b_q;
  logic [6:0]  s2_lo_q;

  always_comb begin
    s2_rem = 17'(s1_a_q) - 17'(s1_qe_q) * 17'(usd_pkg::DayDivOdd);
    if (s2_rem >= 17'(usd_pkg::DayDivOdd)) begin
      s2_qa_d = s1_qe_q + 7'd1;
      s2_ra_d = 10'(s2_rem - 17'(usd_pkg::DayDivOdd));
    end else begin
      s2_qa_d = s1_qe_q;
      s2_ra_d = 10'(s2_rem);
    end
  end

  // Stage 3: estimate {remainder, lower chunk} / 675
  logic [26:0] s3_n;
  logic [44:0] s3_prod;
  logic [16:0] s3_qe_q;
  logic [26:0] s3_n_q;
  logic [6:0]  s3_qa_q;
  logic [6:0]  s3_lo_q;

  assign s3_n    = {s2_ra_q, s2_b_q};
  assign s3_prod = 45'(s3_n) * 45'(usd_pkg::RecipLo);

  // Stage 4: correct, form day count and second of day
  logic [26:0] s4_rem;
  logic [16:0] s4_q;
  logic [9:0]  s4_r;
  logic [23:0] s4_days_q;
  logic [16:0] s4_sod_q;

  always_comb begin
    s4_rem = s3_n_q - 27'(s3_qe_q) * 27'(usd_pkg::DayDivOdd);
    if (s4_rem >= 27'(usd_pkg::DayDivOdd)) begin
      s4_q = s3_qe_q + 17'd1;
      s4_r = 10'(s4_rem - 27'(usd_pkg::DayDivOdd));
    end else begin
      s4_q = s3_qe_q;
      s4_r = 10'(s4_rem);
    end
  end

  // Stage 5: estimate second of day / 60
  logic [27:0] s5_prod;
  logic [10:0] s5_qe_q;
  logic [16:0] s5_sod_q;
  logic [23:0] s5_days_q;

  assign s5_prod = 28'(s4_sod_q) * 28'(usd_pkg::RecipSod);

  // Stage 6: correct to minute of day and second
  logic [16:0] s6_rem;
  logic [10:0] s6_mt_d;
  logic [5:0]  s6_sec_d;
  logic [10:0] s6_mt_q;
  logic [5:0]  s6_sec_q;
  logic [23:0] s6_days_q;

  always_comb begin
    s6_rem = s5_sod_q - 17'(s5_qe_q) * 17'(usd_pkg::SixtyDiv);
    if (s6_rem >= 17'(usd_pkg::SixtyDiv)) begin
      s6_mt_d  = s5_qe_q + 11'd1;
      s6_sec_d = 6'(s6_rem - 17'(usd_pkg::SixtyDiv));
    end else begin
      s6_mt_d  = s5_qe_q;
      s6_sec_d = 6'(s6_rem);
    end
  end

  // Stage 7: estimate minute of day / 60
  logic [16:0] s7_prod;
  logic [4:0]  s7_qe_q;
  logic [10:0] s7_mt_q;
  logic [5:0]  s7_sec_q;
  logic [23:0] s7_days_q;

  assign s7_prod = 17'(s6_mt_q) * 17'(usd_pkg::RecipMt);

  // Stage 8: correct to hour and minute
  logic [10:0]   s8_rem;
  usd_pkg::tod_t s8_tod_d;
  usd_pkg::tod_t s8_tod_q;
  logic [23:0]   s8_days_q;

  always_comb begin
    s8_rem       = s7_mt_q - 11'(s7_qe_q) * 11'(usd_pkg::SixtyDiv);
    s8_tod_d.sec = s7_sec_q;
    if (s8_rem >= 11'(usd_pkg::SixtyDiv)) begin
      s8_tod_d.hour = s7_qe_q + 5'd1;
      s8_tod_d.min  = 6'(s8_rem - 11'(usd_pkg::SixtyDiv));
    end else begin
      s8_tod_d.hour = s7_qe_q;
      s8_tod_d.min  = 6'(s8_rem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_qe_q <= s1_prod[22:16];
      s1_a_q  <= s1_x[32:17];
      s1_b_q  <= s1_x[16:0];
      s1_lo_q <= unix_seconds_i[usd_pkg::DayShift-1:0];
    end
    if (en[1]) begin
      s2_qa_q <= s2_qa_d;
      s2_ra_q <= s2_ra_d;
      s2_b_q  <= s1_b_q;
      s2_lo_q <= s1_lo_q;
    end
    if (en[2]) begin
      s3_qe_q <= s3_prod[43:27];
      s3_n_q  <= s3_n;
      s3_qa_q <= s2_qa_q;
      s3_lo_q <= s2_lo_q;
    end
    if (en[3]) begin
      s4_days_q <= {s3_qa_q, s4_q};
      s4_sod_q  <= {s4_r, s3_lo_q};
    end
    if (en[4]) begin
      s5_qe_q   <= s5_prod[27:17];
      s5_sod_q  <= s4_sod_q;
      s5_days_q <= s4_days_q;
    end
    if (en[5]) begin
      s6_mt_q   <= s6_mt_d;
      s6_sec_q  <= s6_sec_d;
      s6_days_q <= s5_days_q;
    end
    if (en[6]) begin
      s7_qe_q   <= s7_prod[15:11];
      s7_mt_q   <= s6_mt_q;
      s7_sec_q  <= s6_sec_q;
      s7_days_q <= s6_days_q;
    end
    if (en[7]) begin
      s8_tod_q  <= s8_tod_d;
      s8_days_q <= s7_days_q;
    end
  end

  assign days_o = s8_days_q;
  assign tod_o  = s8_tod_q;

  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (tod_o.sec < 6'd60) && (tod_o.min < 6'd60) && (tod_o.hour < 5'd24))
    else $error("time of day out of range");

endmodule

### design/usd_civil.sv
// ----------------------------------------------------------------------------
// usd_civil: day count to Gregorian year, month and day
// Integer Julian-day scheme with Jan/Feb as months 13/14 of the prior year.
// Also hands the shifted year and month to the weekday section.
// ----------------------------------------------------------------------------
module usd_civil (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [23:0]     days_i,
  input  usd_pkg::tod_t   tod_i,
  output logic            valid_o,
  input  logic            ready_i,
  output usd_pkg::date_t  date_o,
  output logic [15:0]     zyear_o,
  output logic [3:0]      zmonth_o,
  output usd_pkg::tod_t   tod_o
);

  localparam int Depth = usd_pkg::CivilDepth;

  logic [Depth-1:0] en;

  usd_pipe_ctl #(.Depth(Depth)) u_ctl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .valid_o (valid_o),
    .ready_i (ready_i),
    .en_o    (en)
  );

  // Time of day rides along every stage
  usd_pkg::tod_t tod_q [Depth];

  // Stage 1: 4 * days + 102032
  logic [25:0] c1_num_q;
  logic [23:0] c1_days_q;

  // Stage 2: estimate / 146097
  logic [34:0] c2_prod;
  logic [8:0]  c2_qe_q;
  logic [25:0] c2_num_q;
  logic [23:0] c2_days_q;

  assign c2_prod = 35'(c1_num_q) * 35'(usd_pkg::CentRecip);

  // Stage 3: correct, add bias
  logic [25:0] c3_rem;
  logic [8:0]  c3_ga_d;
  logic [8:0]  c3_ga_q;
  logic [23:0] c3_days_q;

  always_comb begin
    c3_rem = c2_num_q - 26'(c2_qe_q) * 26'(usd_pkg::CentDiv);
    if (c3_rem >= 26'(usd_pkg::CentDiv)) begin
      c3_ga_d = c2_qe_q + 9'(usd_pkg::CentBias + 1);
    end else begin
      c3_ga_d = c2_qe_q + 9'(usd_pkg::CentBias);
    end
  end

  // Stage 4: gb
  logic [23:0] c4_gb_q;

  // Stage 5: 20 * gb - 2442
  logic [28:0] c5_num_q;
  logic [23:0] c5_gb_q;

  // Stage 6: estimate / 7305
  logic [45:0] c6_prod;
  logic [15:0] c6_qe_q;
  logic [28:0] c6_num_q;
  logic [23:0] c6_gb_q;

  assign c6_prod = 46'(c5_num_q) * 46'(usd_pkg::YrRecip);

  // Stage 7: correct to Julian-scheme year
  logic [28:0] c7_rem;
  logic [15:0] c7_yr_d;
  logic [15:0] c7_yr_q;
  logic [23:0] c7_gb_q;

  always_comb begin
    c7_rem = c6_num_q - 29'(c6_qe_q) * 29'(usd_pkg::YrDiv);
    if (c7_rem >= 29'(usd_pkg::YrDiv)) begin
      c7_yr_d = c6_qe_q + 16'd1;
    end else begin
      c7_yr_d = c6_qe_q;
    end
  end

  // Stage 8: day within the shifted year
  logic [23:0] c8_dy;
  logic [8:0]  c8_dy_q;
  logic [15:0] c8_yr_q;

  assign c8_dy = c7_gb_q - 24'(c7_yr_q) * 24'(usd_pkg::DaysInYear) - 24'(c7_yr_q >> 2);

  // Stage 9: month index
  logic [3:0]  c9_mo_q;
  logic [8:0]  c9_dy_q;
  logic [15:0] c9_yr_q;

  // Stage 10: day of month, calendar month and year
  logic [8:0]     c10_dm;
  usd_pkg::date_t c10_date_d;
  usd_pkg::date_t c10_date_q;
  logic [15:0]    c10_zy_q;
  logic [3:0]     c10_zm_q;

  always_comb begin
    c10_dm = c9_dy_q - 9'(c9_mo_q) * 9'(usd_pkg::MonthDays)
           - 9'(usd_pkg::month_frac(c9_mo_q));
    c10_date_d.day = c10_dm[4:0];
    if (c9_mo_q <= 4'(usd_pkg::LastShifted)) begin
      c10_date_d.year  = c9_yr_q - 16'(usd_pkg::YrOffLo);
      c10_date_d.month = c9_mo_q - 4'd1;
    end else begin
      c10_date_d.year  = c9_yr_q - 16'(usd_pkg::YrOffHi);
      c10_date_d.month = c9_mo_q - 4'(usd_pkg::LastShifted);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c1_num_q  <= (26'(days_i) << 2) + 26'(usd_pkg::CentNum);
      c1_days_q <= days_i;
      tod_q[0]  <= tod_i;
    end
    for (int k = 1; k < Depth; k++) begin
      if (en[k]) tod_q[k] <= tod_q[k-1];
    end
    if (en[1]) begin
      c2_qe_q   <= c2_prod[34:26];
      c2_num_q  <= c1_num_q;
      c2_days_q <= c1_days_q;
    end
    if (en[2]) begin
      c3_ga_q   <= c3_ga_d;
      c3_days_q <= c2_days_q;
    end
    if (en[3]) begin
      c4_gb_q <= c3_days_q + 24'(usd_pkg::GbOffset) + 24'(c3_ga_q) - 24'(c3_ga_q >> 2);
    end
    if (en[4]) begin
      c5_num_q <= (29'(c4_gb_q) << 4) + (29'(c4_gb_q) << 2) - 29'(usd_pkg::YrSub);
      c5_gb_q  <= c4_gb_q;
    end
    if (en[5]) begin
      c6_qe_q  <= c6_prod[44:29];
      c6_num_q <= c5_num_q;
      c6_gb_q  <= c5_gb_q;
    end
    if (en[6]) begin
      c7_yr_q <= c7_yr_d;
      c7_gb_q <= c6_gb_q;
    end
    if (en[7]) begin
      c8_dy_q <= c8_dy[8:0];
      c8_yr_q <= c7_yr_q;
    end
    if (en[8]) begin
      c9_mo_q <= usd_pkg::month_index(c8_dy_q);
      c9_dy_q <= c8_dy_q;
      c9_yr_q <= c8_yr_q;
    end
    if (en[9]) begin
      c10_date_q <= c10_date_d;
      // Zeller wants Jan/Feb as months 13/14 of the year before: same shift for all
      c10_zy_q   <= c9_yr_q - 16'(usd_pkg::YrOffLo);
      c10_zm_q   <= c9_mo_q - 4'd1;
    end
  end

  assign date_o   = c10_date_q;
  assign zyear_o  = c10_zy_q;
  assign zmonth_o = c10_zm_q;
  assign tod_o    = tod_q[Depth-1];

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (date_o.month >= 4'd1) && (date_o.month <= 4'd12) && (date_o.day != 5'd0))
    else $error("calendar month or day out of range");

  a_year_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (date_o.year >= 16'd1970))
    else $error("year below epoch");

  a_zeller_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (zmonth_o >= 4'd3) && (zmonth_o <= 4'd14))
    else $error("shifted month out of range");

endmodule

### design/usd_wday.sv
// ----------------------------------------------------------------------------
// usd_wday: weekday by Zeller's congruence
// Splits the shifted year into century and year of century, sums the
// congruence terms and reduces mod 7 to 1 (Monday) .. 7 (Sunday).
// ----------------------------------------------------------------------------
module usd_wday (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  usd_pkg::date_t  date_i,
  input  logic [15:0]     zyear_i,
  input  logic [3:0]      zmonth_i,
  input  usd_pkg::tod_t   tod_i,
  output logic            valid_o,
  input  logic            ready_i,
  output usd_pkg::date_t  date_o,
  output usd_pkg::tod_t   tod_o,
  output logic [2:0]      weekday_o
);

  localparam int Depth = usd_pkg::WdayDepth;

  logic [Depth-1:0] en;

  usd_pipe_ctl #(.Depth(Depth)) u_ctl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .valid_o (valid_o),
    .ready_i (ready_i),
    .en_o    (en)
  );

  usd_pkg::tod_t  tod_q  [Depth];
  usd_pkg::date_t date_q [Depth];

  // Stage 1: estimate year / 100, month term
  logic [25:0] w1_prod;
  logic [9:0]  w1_qe_q;
  logic [15:0] w1_zy_q;
  logic [5:0]  w1_tm_q;

  assign w1_prod = 26'(zyear_i) * 26'(usd_pkg::HundredRecip);

  // Stage 2: correct to century and year of century
  logic [15:0] w2_rem;
  logic [9:0]  w2_cent_d;
  logic [6:0]  w2_yoc_d;
  logic [9:0]  w2_cent_q;
  logic [6:0]  w2_yoc_q;
  logic [5:0]  w2_tm_q;

  always_comb begin
    w2_rem = w1_zy_q - 16'(w1_qe_q) * 16'(usd_pkg::HundredDiv);
    if (w2_rem >= 16'(usd_pkg::HundredDiv)) begin
      w2_cent_d = w1_qe_q + 10'd1;
      w2_yoc_d  = 7'(w2_rem - 16'(usd_pkg::HundredDiv));
    end else begin
      w2_cent_d = w1_qe_q;
      w2_yoc_d  = 7'(w2_rem);
    end
  end

  // Stage 3: congruence sum plus offset
  logic [11:0] w3_h;
  logic [11:0] w3_h_q;

  assign w3_h = 12'(date_q[1].day) + 12'(w2_tm_q) + 12'(w2_yoc_q) + 12'(w2_yoc_q >> 2)
              + 12'(w2_cent_q) * 12'd5 + 12'(w2_cent_q >> 2) + 12'(usd_pkg::WeekBias);

  // Stage 4: estimate / 7
  logic [21:0] w4_prod;
  logic [9:0]  w4_qe_q;
  logic [11:0] w4_h_q;

  assign w4_prod = 22'(w3_h_q) * 22'(usd_pkg::WeekRecip);

  // Stage 5: correct, weekday = remainder + 1
  logic [11:0] w5_rem;
  logic [2:0]  w5_wd_d;
  logic [2:0]  w5_wd_q;

  always_comb begin
    w5_rem = w4_h_q - 12'(w4_qe_q) * 12'(usd_pkg::WeekDiv);
    if (w5_rem >= 12'(usd_pkg::WeekDiv)) begin
      w5_wd_d = 3'(w5_rem - 12'(usd_pkg::WeekDiv)) + 3'd1;
    end else begin
      w5_wd_d = 3'(w5_rem) + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      w1_qe_q   <= w1_prod[25:16];
      w1_zy_q   <= zyear_i;
      w1_tm_q   <= usd_pkg::zeller_month_term(zmonth_i);
      tod_q[0]  <= tod_i;
      date_q[0] <= date_i;
    end
    for (int k = 1; k < Depth; k++) begin
      if (en[k]) begin
        tod_q[k]  <= tod_q[k-1];
        date_q[k] <= date_q[k-1];
      end
    end
    if (en[1]) begin
      w2_cent_q <= w2_cent_d;
      w2_yoc_q  <= w2_yoc_d;
      w2_tm_q   <= w1_tm_q;
    end
    if (en[2]) w3_h_q <= w3_h;
    if (en[3]) begin
      w4_qe_q <= w4_prod[21:12];
      w4_h_q  <= w3_h_q;
    end
    if (en[4]) w5_wd_q <= w5_wd_d;
  end

  assign date_o    = date_q[Depth-1];
  assign tod_o     = tod_q[Depth-1];
  assign weekday_o = w5_wd_q;

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (weekday_o != 3'd0))
    else $error("weekday out of range");

endmodule

### design/unix_seconds_to_date.sv
// ----------------------------------------------------------------------------
// unix_seconds_to_date: Unix time to calendar date, time of day and weekday
// Top level: time split, civil date and weekday pipeline sections in series.
// ----------------------------------------------------------------------------
// Takes one 40-bit count of seconds since 1970-01-01 00:00:00 UTC per
// transaction and returns seconds, minutes, hours, day, month, year and ISO
// weekday (1 Monday .. 7 Sunday). The block accepts one transaction every
// cycle while the output is not stalled. The item passes 23 register stages,
// and the accepting edge loads the first of them. The stages are the 8-stage
// time split, the 10-stage Julian-day date conversion and the 5-stage Zeller
// weekday section. Each stage holds its own valid bit, so a stall on the
// output backs up one stage at a time and empty stages keep filling. No
// configuration, no state between transactions.
module unix_seconds_to_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [39:0] unix_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_of_year_o,
  output logic [15:0] year_number_o,
  output logic [2:0]  weekday_number_o
);

  logic           ts_valid;
  logic           ts_ready;
  logic [23:0]    ts_days;
  usd_pkg::tod_t  ts_tod;

  logic           cv_valid;
  logic           cv_ready;
  usd_pkg::date_t cv_date;
  logic [15:0]    cv_zyear;
  logic [3:0]     cv_zmonth;
  usd_pkg::tod_t  cv_tod;

  usd_pkg::date_t wd_date;
  usd_pkg::tod_t  wd_tod;

  usd_tsplit u_tsplit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .unix_seconds_i (unix_seconds_i),
    .valid_o        (ts_valid),
    .ready_i        (ts_ready),
    .days_o         (ts_days),
    .tod_o          (ts_tod)
  );

  usd_civil u_civil (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ts_valid),
    .ready_o  (ts_ready),
    .days_i   (ts_days),
    .tod_i    (ts_tod),
    .valid_o  (cv_valid),
    .ready_i  (cv_ready),
    .date_o   (cv_date),
    .zyear_o  (cv_zyear),
    .zmonth_o (cv_zmonth),
    .tod_o    (cv_tod)
  );

  usd_wday u_wday (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (cv_valid),
    .ready_o   (cv_ready),
    .date_i    (cv_date),
    .zyear_i   (cv_zyear),
    .zmonth_i  (cv_zmonth),
    .tod_i     (cv_tod),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .date_o    (wd_date),
    .tod_o     (wd_tod),
    .weekday_o (weekday_number_o)
  );

  assign second_of_minute_o = wd_tod.sec;
  assign minute_of_hour_o   = wd_tod.min;
  assign hour_of_day_o      = wd_tod.hour;
  assign day_of_month_o     = wd_date.day;
  assign month_of_year_o    = wd_date.month;
  assign year_number_o      = wd_date.year;

endmodule
